// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

    // Default sizes
    localparam int ENTRIES_DEF  = 8;
    localparam int KEY_BITS_DEF = 64;

    // Field widths fixed by the interface
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int CAP_W   = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // Register index
    localparam logic CAP_REG = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef enum logic
    {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed
    {
        logic capture;   // register key compare against the incoming key
        logic update;    // apply the recency update this cycle
        logic is_add;    // update is an insert at the front
        logic hit;       // update is a get hit
    } cell_ctrl_t;

endpackage

// ===== hdl/lkvc_cell.sv =====
module lkvc_cell #(
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkvc_pkg::cell_ctrl_t         ctrl,
    input  logic [KEY_BITS-1:0]          probe_key,
    input  logic                         keep,
    input  logic                         seen_in,
    input  logic                         prev_valid,
    input  logic [KEY_BITS-1:0]          prev_key,
    input  logic [lkvc_pkg::VALUE_W-1:0] prev_value,
    input  logic                         prev_dbl,
    output logic                         seen_out,
    output logic                         sel,
    output logic                         valid,
    output logic [KEY_BITS-1:0]          key,
    output logic [lkvc_pkg::VALUE_W-1:0] value,
    output logic                         dbl
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         match_reg;
    logic                         match_next;
    logic [KEY_BITS-1:0]          key_reg;
    logic [lkvc_pkg::VALUE_W-1:0] value_reg;
    logic                         dbl_reg;
    logic                         shift;

    // Take the left neighbor's entry on an add, or on a hit at or beyond this cell
    assign shift = ctrl.update && (ctrl.is_add || (ctrl.hit && !seen_in));

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = valid_reg && (key_reg == probe_key);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (shift)
        begin
            valid_next = prev_valid;
        end
        // Trim to capacity after an add or a hit
        if (ctrl.update && (ctrl.is_add || ctrl.hit) && !keep)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
            dbl_reg   <= prev_dbl;
        end
    end

    // First match along the chain is the most recently used one
    assign sel      = match_reg && !seen_in;
    assign seen_out = seen_in || match_reg;
    assign valid    = valid_reg;
    assign key      = key_reg;
    assign value    = value_reg;
    assign dbl      = dbl_reg;

endmodule

// ===== hdl/lru_key_value_cache_unit.sv =====
// Fully associative LRU key/value cache built as a chain of cells kept in
// recency order: cell 0 holds the most recently used entry. An add (req_type 0)
// shifts every entry one cell down and places the new one in cell 0; a get
// (req_type 1) moves the first matching entry to cell 0 and returns its value
// and type tag, or hit = 0 with zero data on a miss. Entries beyond the
// capacity register (0 counts as 1, values above ENTRIES act as ENTRIES) are
// dropped after an add or a hit. An add with a held key makes a second entry.
// Each item is handled first in ST_IDLE, in which every cell compares its key
// with the incoming key, and then in ST_UPDATE, in which the chain shifts and
// the result is registered. A get waits in ST_UPDATE while the previous result
// is still stalled at the output. Adds return nothing.
module lru_key_value_cache_unit #(
    parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
    output logic [lkvc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [lkvc_pkg::KEY_W-1:0]    lookup_key,
    input  logic [lkvc_pkg::VALUE_W-1:0]  new_value,
    input  logic                          new_is_double,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [lkvc_pkg::VALUE_W-1:0]  found_value,
    output logic                          found_is_double
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    lkvc_pkg::state_t     state_reg;
    lkvc_pkg::state_t     state_next;
    lkvc_pkg::cell_ctrl_t ctrl;

    logic [lkvc_pkg::CAP_W-1:0]   capacity_reg;
    logic [CMP_W-1:0]             cap_ext;
    logic [CMP_W-1:0]             limit;

    logic                         req_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [lkvc_pkg::VALUE_W-1:0] value_reg;
    logic                         dbl_reg;

    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [lkvc_pkg::VALUE_W-1:0] found_value_reg;
    logic                         found_dbl_reg;

    logic                         accept;
    logic                         done;
    logic                         is_get;
    logic                         any_hit;
    logic [KEY_BITS-1:0]          hit_key;
    logic [lkvc_pkg::VALUE_W-1:0] hit_value;
    logic                         hit_dbl;

    // Chain wiring
    logic [ENTRIES:0]             seen;
    logic [ENTRIES:0]             ch_valid;
    logic [KEY_BITS-1:0]          ch_key   [ENTRIES+1];
    logic [lkvc_pkg::VALUE_W-1:0] ch_value [ENTRIES+1];
    logic [ENTRIES:0]             ch_dbl;
    logic [ENTRIES-1:0]           sel;
    logic [ENTRIES-1:0]           keep;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lkvc_pkg::CAP_REG)
                    ? lkvc_pkg::DATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == lkvc_pkg::CAP_REG))
        begin
            capacity_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    // Effective capacity
    assign cap_ext = CMP_W'(capacity_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            limit = CMP_W'(ENTRIES);
        end
        else
        begin
            limit = cap_ext;
        end
    end

    // Handshake
    assign accept = in_valid && !in_stall;
    assign is_get = (req_reg == lkvc_pkg::REQ_GET);
    assign done   = !(is_get && out_valid_reg && out_stall);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lkvc_pkg::ST_UPDATE;
                end
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (done)
                begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall     = 1'b1;
        ctrl.capture = 1'b0;
        ctrl.update  = 1'b0;
        ctrl.is_add  = (req_reg == lkvc_pkg::REQ_ADD);
        ctrl.hit     = is_get && any_hit;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                ctrl.capture = in_valid;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                ctrl.update = done;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Request holding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= lkvc_pkg::REQ_ADD;
        end
        else if (accept)
        begin
            req_reg <= req_type;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= lookup_key[KEY_BITS-1:0];
            value_reg <= new_value;
            dbl_reg   <= new_is_double;
        end
    end

    // Select the hit entry
    always_comb
    begin
        hit_key   = '0;
        hit_value = '0;
        hit_dbl   = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel[i])
            begin
                hit_key   = hit_key   | ch_key[i+1];
                hit_value = hit_value | ch_value[i+1];
                hit_dbl   = hit_dbl   | ch_dbl[i+1];
            end
        end
    end

    assign any_hit = seen[ENTRIES];

    // Front of the chain: new entry on add, hit entry on get
    assign seen[0]     = 1'b0;
    assign ch_valid[0] = 1'b1;
    assign ch_key[0]   = ctrl.is_add ? key_reg   : hit_key;
    assign ch_value[0] = ctrl.is_add ? value_reg : hit_value;
    assign ch_dbl[0]   = ctrl.is_add ? dbl_reg   : hit_dbl;

    // Row of cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : gen_cell
        assign keep[g] = (CMP_W'(g) < limit);

        lkvc_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .probe_key  (lookup_key[KEY_BITS-1:0]),
            .keep       (keep[g]),
            .seen_in    (seen[g]),
            .prev_valid (ch_valid[g]),
            .prev_key   (ch_key[g]),
            .prev_value (ch_value[g]),
            .prev_dbl   (ch_dbl[g]),
            .seen_out   (seen[g+1]),
            .sel        (sel[g]),
            .valid      (ch_valid[g+1]),
            .key        (ch_key[g+1]),
            .value      (ch_value[g+1]),
            .dbl        (ch_dbl[g+1])
        );
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.update && is_get)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update && is_get)
        begin
            hit_reg         <= any_hit;
            found_value_reg <= any_hit ? hit_value : '0;
            found_dbl_reg   <= any_hit && hit_dbl;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign found_value     = found_value_reg;
    assign found_is_double = found_dbl_reg;

endmodule
